// ----- hw/rtl/smm_pkg.sv -----
// shared widths, constants and types for the square matrix multiplier
// no dependencies; used by every module under hw/rtl
`default_nettype none

package smm_pkg;

  localparam int DIM_W  = 4;   // matrix size register
  localparam int IDX_W  = 3;   // row / column / k index
  localparam int DEPTH  = 64;  // entries per matrix store
  localparam int ADDR_W = 6;   // store address
  localparam int CNT_W  = 7;   // loaded element count, holds up to DEPTH
  localparam int VAL_W  = 16;  // Q8.8 element
  localparam int PROD_W = 32;  // Q16.16 product
  localparam int ACC_W  = 40;  // Q24.16 dot product

  localparam logic [DIM_W-1:0] MAX_DIM = 4'd8;

  // one issue slot of the multiply-accumulate pipeline
  typedef struct packed {
    logic issue;  // operands are being read this cycle
    logic first;  // first term of a dot product
    logic last;   // last term of a dot product
  } mac_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/smm_store.sv -----
// left and right matrix stores, one write port and one registered read port each
// depends on smm_pkg
`default_nettype none

module smm_store (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [smm_pkg::ADDR_W-1:0]       wr_addr,
  input  wire logic signed [smm_pkg::VAL_W-1:0] a_wr,
  input  wire logic signed [smm_pkg::VAL_W-1:0] b_wr,
  input  wire logic [smm_pkg::ADDR_W-1:0]       a_addr,
  input  wire logic [smm_pkg::ADDR_W-1:0]       b_addr,
  output logic signed [smm_pkg::VAL_W-1:0]      a_rd,
  output logic signed [smm_pkg::VAL_W-1:0]      b_rd
);

  logic [smm_pkg::VAL_W-1:0] left_mem  [smm_pkg::DEPTH];
  logic [smm_pkg::VAL_W-1:0] right_mem [smm_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_addr]  <= a_wr;
      right_mem[wr_addr] <= b_wr;
    end
  end

  always_ff @(posedge clk) begin
    a_rd <= left_mem[a_addr];
    b_rd <= right_mem[b_addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/smm_mac.sv -----
// shared multiply-accumulate: register the read data tag, multiply, accumulate
// depends on smm_pkg
`default_nettype none

module smm_mac (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire smm_pkg::mac_ctl_t                ctl,
  input  wire logic signed [smm_pkg::VAL_W-1:0] a_rd,
  input  wire logic signed [smm_pkg::VAL_W-1:0] b_rd,
  output logic signed [smm_pkg::ACC_W-1:0]      acc,
  output logic                                  done
);

  smm_pkg::mac_ctl_t               rd_tag;
  smm_pkg::mac_ctl_t               prod_tag;
  logic signed [smm_pkg::PROD_W-1:0] prod;

  // tags follow the operands through the read and multiply stages
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag   <= '0;
      prod_tag <= '0;
      done     <= 1'b0;
    end else begin
      rd_tag   <= ctl;
      prod_tag <= rd_tag;
      done     <= prod_tag.issue && prod_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_rd * b_rd;
  end

  always_ff @(posedge clk) begin
    if (prod_tag.issue) begin
      if (prod_tag.first) begin
        acc <= smm_pkg::ACC_W'(prod);
      end else begin
        acc <= acc + smm_pkg::ACC_W'(prod);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/smm_seq.sv -----
// sequencer: load counting, operand address walk over i/j/k, result register
// depends on smm_pkg
`default_nettype none

module smm_seq (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [smm_pkg::DIM_W-1:0]        n_dim,
  input  wire logic                             cfg_we,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  output logic                                  wr_en,
  output logic [smm_pkg::ADDR_W-1:0]            wr_addr,
  output logic [smm_pkg::ADDR_W-1:0]            a_addr,
  output logic [smm_pkg::ADDR_W-1:0]            b_addr,
  output smm_pkg::mac_ctl_t                     mac_ctl,
  input  wire logic                             mac_done,
  input  wire logic signed [smm_pkg::ACC_W-1:0] acc,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [smm_pkg::ACC_W-1:0]      product_value,
  output logic [smm_pkg::IDX_W-1:0]             row_index,
  output logic [smm_pkg::IDX_W-1:0]             column_index,
  output logic                                  last_element
);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                  state;
  logic [smm_pkg::CNT_W-1:0]   count;
  logic [smm_pkg::IDX_W-1:0]   i_idx, j_idx, k_idx;
  logic [smm_pkg::ADDR_W-1:0]  row_base;
  logic [smm_pkg::IDX_W-1:0]   last_idx;
  logic [smm_pkg::ADDR_W-1:0]  n_step;
  logic [2*smm_pkg::DIM_W-1:0] total;
  logic                        load_last;
  logic                        emit_go;
  logic                        run_last;

  assign last_idx  = smm_pkg::IDX_W'(n_dim - 1'b1);
  assign n_step    = smm_pkg::ADDR_W'(n_dim);
  assign total     = (2*smm_pkg::DIM_W)'(n_dim) * (2*smm_pkg::DIM_W)'(n_dim);
  assign load_last = ((2*smm_pkg::DIM_W)'(count) + 1'b1) == total;

  assign in_stall = (state != ST_LOAD);
  assign wr_en    = in_valid && !in_stall;
  assign wr_addr  = count[smm_pkg::ADDR_W-1:0];

  assign mac_ctl.issue = (state == ST_ISSUE);
  assign mac_ctl.first = (k_idx == '0);
  assign mac_ctl.last  = (k_idx == last_idx);

  // result register is free when empty or being taken this cycle
  assign emit_go  = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign run_last = (i_idx == last_idx) && (j_idx == last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (cfg_we) begin
            count <= '0;
          end else if (wr_en) begin
            if (load_last) begin
              count <= '0;
              state <= ST_ISSUE;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
        ST_ISSUE: begin
          if (mac_ctl.last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (mac_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            state <= run_last ? ST_LOAD : ST_ISSUE;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // address walk: a runs along row i, b runs down column j in steps of n
  always_ff @(posedge clk) begin
    if (state == ST_LOAD && wr_en && load_last) begin
      i_idx    <= '0;
      j_idx    <= '0;
      k_idx    <= '0;
      row_base <= '0;
      a_addr   <= '0;
      b_addr   <= '0;
    end else if (state == ST_ISSUE && !mac_ctl.last) begin
      k_idx  <= k_idx + 1'b1;
      a_addr <= a_addr + 1'b1;
      b_addr <= b_addr + n_step;
    end else if (emit_go) begin
      k_idx <= '0;
      if (j_idx == last_idx) begin
        j_idx    <= '0;
        i_idx    <= i_idx + 1'b1;
        row_base <= row_base + n_step;
        a_addr   <= row_base + n_step;
        b_addr   <= '0;
      end else begin
        j_idx  <= j_idx + 1'b1;
        a_addr <= row_base;
        b_addr <= smm_pkg::ADDR_W'(j_idx) + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      product_value <= acc;
      row_index     <= i_idx;
      column_index  <= j_idx;
      last_element  <= run_last;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/square_matrix_multiply.sv -----
// top level of the square matrix multiplier: size register, stores, shared mac, sequencer
// depends on smm_pkg, smm_store, smm_mac, smm_seq
//
// channel   direction  handshake              payload
// config    in         cfg_we                 cfg_data (matrix size, 0 acts as 1, >8 as 8)
// input     in         in_valid / in_stall    a_value, b_value (Q8.8, row-major)
// output    out        out_valid / out_stall  product_value, row_index, column_index,
//                                             last_element
//
// the last of n*n input transactions starts the product run
// each product element issues its n terms one after another on the one shared multiplier,
// then passes through read, multiply and accumulate and an emit step before the next begins
// in_stall is high for the whole run; a full result register holds the run at its next
// element until the downstream side takes the pending transaction
// rst is synchronous: size returns to 8, the load count to 0, the output empties
`default_nettype none

module square_matrix_multiply (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [smm_pkg::DIM_W-1:0]        cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [smm_pkg::VAL_W-1:0] a_value,
  input  wire logic signed [smm_pkg::VAL_W-1:0] b_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [smm_pkg::ACC_W-1:0]      product_value,
  output logic [smm_pkg::IDX_W-1:0]             row_index,
  output logic [smm_pkg::IDX_W-1:0]             column_index,
  output logic                                  last_element
);

  logic [smm_pkg::DIM_W-1:0]         n_dim;
  logic [smm_pkg::DIM_W-1:0]         n_dim_next;
  logic                              wr_en;
  logic [smm_pkg::ADDR_W-1:0]        wr_addr;
  logic [smm_pkg::ADDR_W-1:0]        a_addr;
  logic [smm_pkg::ADDR_W-1:0]        b_addr;
  logic signed [smm_pkg::VAL_W-1:0]  a_rd;
  logic signed [smm_pkg::VAL_W-1:0]  b_rd;
  smm_pkg::mac_ctl_t                 mac_ctl;
  logic signed [smm_pkg::ACC_W-1:0]  acc;
  logic                              mac_done;

  // clamp the written size into 1..8
  always_comb begin
    if (cfg_data == '0) begin
      n_dim_next = smm_pkg::DIM_W'(1);
    end else if (cfg_data > smm_pkg::MAX_DIM) begin
      n_dim_next = smm_pkg::MAX_DIM;
    end else begin
      n_dim_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_dim <= smm_pkg::MAX_DIM;
    end else if (cfg_we) begin
      n_dim <= n_dim_next;
    end
  end

  smm_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .a_wr    (a_value),
    .b_wr    (b_value),
    .a_addr  (a_addr),
    .b_addr  (b_addr),
    .a_rd    (a_rd),
    .b_rd    (b_rd)
  );

  smm_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a_rd (a_rd),
    .b_rd (b_rd),
    .acc  (acc),
    .done (mac_done)
  );

  smm_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .n_dim         (n_dim),
    .cfg_we        (cfg_we),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .a_addr        (a_addr),
    .b_addr        (b_addr),
    .mac_ctl       (mac_ctl),
    .mac_done      (mac_done),
    .acc           (acc),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .product_value (product_value),
    .row_index     (row_index),
    .column_index  (column_index),
    .last_element  (last_element)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench for square_matrix_multiply: directed table, then randomized loads
// predicts every product element in-house and checks results in order; needs smm_pkg and the rtl
`default_nettype none

module tb;

  localparam int ITEM_TARGET   = 290;   // no new random phase starts once this many pairs are sent
  localparam int SETTLE_CYCLES = 20;    // quiet cycles before a size write
  localparam int DRAIN_CYCLES  = 100;
  localparam int HOLD_AT       = 20;    // product count that starts the long hold-off
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;

  typedef enum logic {ROW_CFG, ROW_PAIR} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [smm_pkg::DIM_W-1:0]        size;
    logic signed [smm_pkg::VAL_W-1:0] a;
    logic signed [smm_pkg::VAL_W-1:0] b;
    logic                             pinned;  // product typed in, size one only
    logic signed [smm_pkg::ACC_W-1:0] value;
  } row_t;

  typedef struct packed {
    logic signed [smm_pkg::ACC_W-1:0] value;
    logic [smm_pkg::IDX_W-1:0]        row;
    logic [smm_pkg::IDX_W-1:0]        col;
    logic                             last;
  } product_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [smm_pkg::DIM_W-1:0]        cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic signed [smm_pkg::VAL_W-1:0] a_value = '0;
  logic signed [smm_pkg::VAL_W-1:0] b_value = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [smm_pkg::ACC_W-1:0] product_value;
  logic [smm_pkg::IDX_W-1:0]        row_index;
  logic [smm_pkg::IDX_W-1:0]        column_index;
  logic                             last_element;

  square_matrix_multiply dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .a_value       (a_value),
    .b_value       (b_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .product_value (product_value),
    .row_index     (row_index),
    .column_index  (column_index),
    .last_element  (last_element)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block: size register, both stores and the load count
  logic [smm_pkg::DIM_W-1:0]        size_reg = smm_pkg::MAX_DIM;
  logic signed [smm_pkg::VAL_W-1:0] left_mem [smm_pkg::DEPTH];
  logic signed [smm_pkg::VAL_W-1:0] right_mem [smm_pkg::DEPTH];
  int                               loaded = 0;
  product_t                         expected_products [$];

  int error_count   = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int size_writes   = 0;
  int burst_left    = 0;
  bit hold_done     = 1'b0;
  int quiet_cycles  = 0;

  function automatic int dim_of(input logic [smm_pkg::DIM_W-1:0] size);
    if (size == '0) return 1;
    if (size > smm_pkg::MAX_DIM) return int'(smm_pkg::MAX_DIM);
    return int'(size);
  endfunction

  function automatic logic signed [smm_pkg::VAL_W-1:0] pick_element();
    int draw;
    draw = $urandom_range(0, 7);
    case (draw)
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return smm_pkg::VAL_W'($urandom_range(0, 511)) - 16'sd256;
      default: return smm_pkg::VAL_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // store one pair; the last pair of a load yields the whole product matrix
  task automatic predict_pair(input logic signed [smm_pkg::VAL_W-1:0] a,
                              input logic signed [smm_pkg::VAL_W-1:0] b,
                              input logic pinned,
                              input logic signed [smm_pkg::ACC_W-1:0] pinned_value);
    int n, total, pos;
    logic signed [smm_pkg::ACC_W-1:0] acc;
    product_t p;
    n = dim_of(size_reg);
    total = n * n;
    pos = loaded;
    if (pos >= total) pos = 0;
    left_mem[pos] = a;
    right_mem[pos] = b;
    pos++;
    if (pos < total) begin
      loaded = pos;
      return;
    end
    loaded = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = '0;
        for (int k = 0; k < n; k++)
          acc = acc + left_mem[i*n + k] * right_mem[k*n + j];
        p.value = pinned ? pinned_value : acc;
        p.row   = smm_pkg::IDX_W'(i);
        p.col   = smm_pkg::IDX_W'(j);
        p.last  = (i == n - 1) && (j == n - 1);
        expected_products.push_back(p);
      end
    end
  endtask

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic send_pair(input logic signed [smm_pkg::VAL_W-1:0] a,
                           input logic signed [smm_pkg::VAL_W-1:0] b,
                           input logic pinned,
                           input logic signed [smm_pkg::ACC_W-1:0] pinned_value);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    a_value  <= a;
    b_value  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_pair(a, b, pinned, pinned_value);
  endtask

  // sender waits for every pending product, then lets the block settle
  task automatic write_size(input logic [smm_pkg::DIM_W-1:0] v);
    in_valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data <= v;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    size_reg = v;
    loaded   = 0;
    size_writes++;
  endtask

  always @(posedge clk) begin : check_products
    product_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_products.size() == 0) begin
        report_mismatch("product with nothing pending", product_value, 0);
      end else begin
        want = expected_products.pop_front();
        if (product_value !== want.value)
          report_mismatch("product_value", product_value, want.value);
        if (row_index !== want.row)
          report_mismatch("row_index", row_index, want.row);
        if (column_index !== want.col)
          report_mismatch("column_index", column_index, want.col);
        if (last_element !== want.last)
          report_mismatch("last_element", last_element, want.last);
      end
    end
  end

  // receiver stall pattern: free, random or periodic spans, plus one long hold-off
  initial begin : drive_out_stall
    int mode, span;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(4, 40);
      for (int i = 0; i < span; i++) begin
        @(posedge clk);
        if (!hold_done && results_seen >= HOLD_AT) begin
          hold_done = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= (i % 4) < 2;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transaction for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  row_t plan [29];

  initial begin : stimulus
    logic [smm_pkg::DIM_W-1:0] sz;
    int n, runs, partial;
    logic signed [smm_pkg::VAL_W-1:0] xa, xb;

    plan = '{
      // partial load at the reset size, dropped by the size write
      '{ROW_PAIR, 4'd0, 16'sh1357, 16'sh2468, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'sh8000, 16'sh7FFF, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'shFFFF, 16'sh0001, 1'b0, 40'sd0},
      // size zero acts as one: every pair is a full product
      '{ROW_CFG,  4'd0, 16'sh0000, 16'sh0000, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'sh8000, 16'sh8000, 1'b1, 40'sd1073741824},
      '{ROW_PAIR, 4'd0, 16'sh7FFF, 16'sh7FFF, 1'b1, 40'sd1073676289},
      '{ROW_PAIR, 4'd0, 16'sh8000, 16'sh7FFF, 1'b1, -40'sd1073709056},
      '{ROW_PAIR, 4'd0, 16'sh0000, 16'sh1234, 1'b1, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'sh0100, 16'sh0100, 1'b1, 40'sd65536},
      '{ROW_CFG,  4'd1, 16'sh0000, 16'sh0000, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'sh0001, 16'shFFFF, 1'b1, -40'sd1},
      '{ROW_PAIR, 4'd0, 16'shFFFF, 16'shFFFF, 1'b1, 40'sd1},
      // size above the maximum, load abandoned by a new size
      '{ROW_CFG,  4'd12, 16'sh0000, 16'sh0000, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'sh7FFF, 16'sh8000, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'sh1111, 16'sh2222, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'sh8000, 16'sh8000, 1'b0, 40'sd0},
      '{ROW_CFG,  4'd2, 16'sh0000, 16'sh0000, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'sh0100, 16'sh0200, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'sh8000, 16'sh7FFF, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'sh7FFF, 16'sh8000, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'shFFFF, 16'sh0001, 1'b0, 40'sd0},
      // rewriting the same size still restarts the load
      '{ROW_CFG,  4'd2, 16'sh0000, 16'sh0000, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'sh5555, 16'shAAAA, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'shAAAA, 16'sh5555, 1'b0, 40'sd0},
      '{ROW_CFG,  4'd2, 16'sh0000, 16'sh0000, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'sh0080, 16'shFF80, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'sh7F00, 16'sh00FF, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'shC000, 16'sh4000, 1'b0, 40'sd0},
      '{ROW_PAIR, 4'd0, 16'sh0003, 16'shFFFD, 1'b0, 40'sd0}
    };

    for (int i = 0; i < smm_pkg::DEPTH; i++) begin
      left_mem[i]  = '0;
      right_mem[i] = '0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG)
        write_size(plan[r].size);
      else
        send_pair(plan[r].a, plan[r].b, plan[r].pinned, plan[r].value);
    end

    for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
      case (phase)
        0: sz = 4'd4;
        1: sz = 4'd8;
        2: sz = 4'd15;
        default: sz = ($urandom_range(0, 9) < 7) ? smm_pkg::DIM_W'($urandom_range(0, 5))
                                                 : smm_pkg::DIM_W'($urandom_range(6, 15));
      endcase
      write_size(sz);
      n = dim_of(sz);
      runs = (phase == 0) ? 3 : (n >= 6) ? 1 : $urandom_range(1, 3);

      // broken load: a few pairs, then the size is rewritten
      if (phase > 2 && n > 1 && $urandom_range(0, 3) == 0) begin
        partial = $urandom_range(1, n*n - 1);
        repeat (partial) send_pair(pick_element(), pick_element(), 1'b0, '0);
        write_size(sz);
      end

      repeat (runs) begin
        for (int e = 0; e < n*n; e++) begin
          case (phase)
            1: begin xa = 16'sh8000; xb = 16'sh8000; end  // largest positive sums
            2: begin xa = 16'sh8000; xb = 16'sh7FFF; end  // largest negative sums
            default: begin xa = pick_element(); xb = pick_element(); end
          endcase
          send_pair(xa, xb, 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("loaded %0d pairs under %0d size writes, checked %0d product elements",
             items_sent, size_writes, results_seen);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
